[rtl/core/mol_pkg.sv]
// Shared types and constants for the median-of-loaded-values block.
// No dependencies; used by every module under rtl/core.
package mol_pkg;

    // Field widths
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int BIT_W  = $clog2(VAL_W);

    // Default store depth
    localparam int DEPTH_DEFAULT = 64;

    // Opcodes carried on the input tuser
    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEL_LO,
        ST_SEL_HI,
        ST_FINISH
    } state_t;

    // Response of the radix-select unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [VAL_W-1:0] result;
    } sel_rsp_t;

endpackage

[rtl/core/median_of_loaded_values.sv]
// Median of loaded values: top level with the item sequencer and output register.
// Depends on mol_pkg, mol_store and mol_select.
//
// Usage: input items arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser[0]
// is the opcode: push stores s_tdata as a sample (up to DEPTH samples, extras
// are dropped and flagged), compute emits one result item and empties the store.
// Result items leave on m_tvalid/m_tready/m_tdata/m_tuser: m_tdata is the median
// (16.16), m_tuser the status (ok, empty, overflow).
// Operation: a push is taken whenever the sequencer is idle. A compute runs a
// bit-serial radix select, one pass over the n stored samples per result bit,
// through the memory read port; the select runs once for odd n and twice for
// even n (the two middle samples). A compute on an empty store skips the
// select and goes straight to the finish state.
// s_tready is high only while the sequencer is idle. A finished result sits in
// the output register until taken; pushes are accepted meanwhile, and a later
// compute waits for the register to drain if the receiver stalls.
// Reset clears the fill count, overflow flag and output valid; the sample memory
// itself is not cleared.
module median_of_loaded_values #(
    parameter int DEPTH = mol_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] median
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int VAL_W  = mol_pkg::VAL_W;
    localparam int STAT_W = mol_pkg::STAT_W;

    mol_pkg::state_t      state_reg, state_next;
    mol_pkg::sel_rsp_t    sel_rsp;

    logic                 in_accept;
    logic                 is_compute;
    logic                 push;
    logic                 clear;
    logic [CW-1:0]        count;
    logic                 overflow;
    logic                 empty;
    logic                 even;
    logic [CW-1:0]        half;
    logic [AW-1:0]        rd_addr;
    logic [VAL_W-1:0]     rd_data;

    logic                 sel_start;
    logic [CW-1:0]        sel_k;
    logic                 load_out;
    logic                 out_free;

    logic [VAL_W-1:0]     lo_reg;
    logic [VAL_W-1:0]     med_reg;
    logic [VAL_W:0]       pair_sum;
    logic [VAL_W-1:0]     pair_mean;
    logic [STAT_W-1:0]    status;

    logic                 out_valid_reg;
    logic [VAL_W-1:0]     out_median_reg;
    logic [STAT_W-1:0]    out_status_reg;

    assign s_tready   = (state_reg == mol_pkg::ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign is_compute = (s_tuser[0] == mol_pkg::OP_COMPUTE);
    assign push       = in_accept && !is_compute;
    assign clear      = load_out;
    assign empty      = (count == '0);
    assign even       = !count[0];
    assign half       = count >> 1;
    assign out_free   = !out_valid_reg || m_tready;

    // Mean of the two middle samples, formed one bit wider and halved
    assign pair_sum  = {1'b0, lo_reg} + {1'b0, sel_rsp.result};
    assign pair_mean = pair_sum[VAL_W:1];

    assign status = empty    ? mol_pkg::STAT_EMPTY :
                    overflow ? mol_pkg::STAT_OVERFLOW : mol_pkg::STAT_OK;

    mol_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_value (s_tdata),
        .clear      (clear),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .count      (count),
        .overflow   (overflow)
    );

    mol_select #(
        .DEPTH(DEPTH)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sel_start),
        .k       (sel_k),
        .n       (count),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (sel_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mol_pkg::ST_IDLE:
            begin
                if (in_accept && is_compute)
                begin
                    if (empty)
                        state_next = mol_pkg::ST_FINISH;
                    else if (even)
                        state_next = mol_pkg::ST_SEL_LO;
                    else
                        state_next = mol_pkg::ST_SEL_HI;
                end
            end
            mol_pkg::ST_SEL_LO:
            begin
                if (sel_rsp.done)
                    state_next = mol_pkg::ST_SEL_HI;
            end
            mol_pkg::ST_SEL_HI:
            begin
                if (sel_rsp.done)
                    state_next = mol_pkg::ST_FINISH;
            end
            mol_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = mol_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mol_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: select starts and output load
    always_comb
    begin
        sel_start = 1'b0;
        sel_k     = half;
        load_out  = 1'b0;
        case (state_reg)
            mol_pkg::ST_IDLE:
            begin
                sel_start = in_accept && is_compute && !empty;
                sel_k     = even ? (half - CW'(1)) : half;
            end
            mol_pkg::ST_SEL_LO:
            begin
                sel_start = sel_rsp.done;
                sel_k     = half;
            end
            mol_pkg::ST_SEL_HI:
            begin
                sel_start = 1'b0;
            end
            mol_pkg::ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                sel_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mol_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the lower middle sample and the finished median
    always_ff @(posedge clk)
    begin
        if ((state_reg == mol_pkg::ST_SEL_LO) && sel_rsp.done)
            lo_reg <= sel_rsp.result;
        if ((state_reg == mol_pkg::ST_SEL_HI) && sel_rsp.done)
            med_reg <= even ? pair_mean : sel_rsp.result;
        else if ((state_reg == mol_pkg::ST_IDLE) && in_accept && is_compute && empty)
            med_reg <= '0;
    end

    // Output register: load on finish, drop on handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_median_reg <= med_reg;
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_median_reg;
    assign m_tuser  = out_status_reg;

    // The select unit is free whenever items are being accepted
    a_idle_sel_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mol_pkg::ST_IDLE) |-> !sel_rsp.busy)
        else $error("select unit busy while sequencer idle");

    // Select completions only arrive during a selection state
    a_done_in_sel: assert property (@(posedge clk) disable iff (!rst_n)
        sel_rsp.done |->
            ((state_reg == mol_pkg::ST_SEL_LO) || (state_reg == mol_pkg::ST_SEL_HI)))
        else $error("select done outside a selection state");

    // Fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // A dropped push implies a full store
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow |-> (count == CW'(DEPTH)))
        else $error("overflow flag set with store not full");

    // A finished result with a free output register shows up next cycle
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mol_pkg::ST_FINISH) && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not loaded");

endmodule

[rtl/core/mol_store.sv]
// Sample store: memory of DEPTH samples, fill count and overflow flag.
// Depends on mol_pkg for widths.
module mol_store #(
    parameter int DEPTH = mol_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [mol_pkg::VAL_W-1:0]   push_value,
    input  logic                        clear,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [mol_pkg::VAL_W-1:0]   rd_data,
    output logic [$clog2(DEPTH+1)-1:0]  count,
    output logic                        overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [mol_pkg::VAL_W-1:0] mem [DEPTH];
    logic [mol_pkg::VAL_W-1:0] rd_data_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic                      full;
    logic                      wr_en;

    assign full  = (count_reg == CW'(DEPTH));
    assign wr_en = push && !full;

    // Advance the fill count, flag dropped pushes, empty on clear
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (push)
        begin
            if (full)
                ovf_next = 1'b1;
            else
                count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Write the sample at the fill position
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= push_value;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign count    = count_reg;
    assign overflow = ovf_reg;

endmodule

[rtl/core/mol_select.sv]
// Bit-serial radix select: finds the k-th smallest stored sample (k counts from zero), MSB first,
// one result bit per pass over the store. Depends on mol_pkg.
module mol_select #(
    parameter int DEPTH = mol_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [$clog2(DEPTH+1)-1:0]  k,
    input  logic [$clog2(DEPTH+1)-1:0]  n,
    output logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  logic [mol_pkg::VAL_W-1:0]   rd_data,
    output mol_pkg::sel_rsp_t           rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VAL_W = mol_pkg::VAL_W;
    localparam int BIT_W = mol_pkg::BIT_W;

    logic                busy_reg,   busy_next;
    logic                issue_reg,  issue_next;
    logic                rvalid_reg, rvalid_next;
    logic                rlast_reg,  rlast_next;
    logic                done_reg,   done_next;
    logic [AW-1:0]       idx_reg,    idx_next;
    logic [BIT_W-1:0]    bit_reg,    bit_next;
    logic [CW-1:0]       cnt_reg,    cnt_next;
    logic [CW-1:0]       k_reg,      k_next;
    logic [VAL_W-1:0]    prefix_reg, prefix_next;

    logic [CW-1:0]       n_minus1;
    logic [AW-1:0]       n_last;
    logic [BIT_W:0]      shamt;
    logic                match;
    logic [CW-1:0]       cnt_inc;
    logic                take_one;

    assign n_minus1 = n - CW'(1);
    assign n_last   = n_minus1[AW-1:0];

    // A sample counts when its bits above the current one equal the prefix
    // and its current bit is zero
    assign shamt   = {1'b0, bit_reg} + (BIT_W + 1)'(1);
    assign match   = ((rd_data >> shamt) == prefix_reg) && !rd_data[bit_reg];
    assign cnt_inc = cnt_reg + CW'(match);
    assign take_one = !(k_reg < cnt_inc);

    always_comb
    begin
        busy_next   = busy_reg;
        issue_next  = issue_reg;
        rvalid_next = 1'b0;
        rlast_next  = 1'b0;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        bit_next    = bit_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        prefix_next = prefix_reg;
        if (!busy_reg)
        begin
            // Load a new search
            if (start)
            begin
                busy_next   = 1'b1;
                issue_next  = 1'b1;
                idx_next    = '0;
                bit_next    = BIT_W'(VAL_W - 1);
                cnt_next    = '0;
                k_next      = k;
                prefix_next = '0;
            end
        end
        else
        begin
            // Issue reads across the store
            rvalid_next = issue_reg;
            rlast_next  = issue_reg && (idx_reg == n_last);
            if (issue_reg)
            begin
                if (idx_reg == n_last)
                    issue_next = 1'b0;
                else
                    idx_next = idx_reg + AW'(1);
            end
            // Count matches; at pass end settle one bit
            if (rvalid_reg)
            begin
                if (rlast_reg)
                begin
                    prefix_next = {prefix_reg[VAL_W-2:0], take_one};
                    if (take_one)
                        k_next = k_reg - cnt_inc;
                    cnt_next = '0;
                    if (bit_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        idx_next   = '0;
                        issue_next = 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            issue_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
            rlast_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            issue_reg  <= issue_next;
            rvalid_reg <= rvalid_next;
            rlast_reg  <= rlast_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        bit_reg    <= bit_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        prefix_reg <= prefix_next;
    end

    assign rd_addr    = idx_reg;
    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = prefix_reg;

endmodule
